/* sv/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Types, constants and helpers shared by the curved-to-plane transform.
// ----------------------------------------------------------------------------
package ctp_pkg;

  // restoring divider steps, also the width of each quotient
  localparam int DIV_STEPS  = 33;
  // width of the slice angle divisor, twice the slice count
  localparam int ANG_DIV_W  = 17;
  // bend angle times (2*index - count)
  localparam int ANG_PROD_W = 50;
  // cordic datapath width
  localparam int CW         = 34;

  localparam logic signed [31:0]   PI_Q29      = 32'sd1686629713;
  localparam logic signed [31:0]   HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  // register indexes, address bits [3:2]
  localparam logic [1:0] REG_BEND_RADIUS = 2'd0;
  localparam logic [1:0] REG_BEND_ANGLE  = 2'd1;
  localparam logic [1:0] REG_SLICE_COUNT = 2'd2;

  typedef struct packed {
    logic signed [31:0] x_offset;
    logic signed [31:0] y_offset;
    logic signed [31:0] x_slope;
    logic signed [31:0] y_slope;
    logic [30:0]        momentum;
    logic [15:0]        slice_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
  } rsp_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_lane_t;

  typedef struct packed {
    cordic_lane_t lane;
    logic         flip;
  } cordic_start_t;

  // flags and pass-through data riding along the divider chain
  typedef struct packed {
    logic signed [31:0] x_off;
    logic signed [31:0] y_off;
    logic               ang_neg;
    logic               ang_ovf;
    logic               ax_neg;
    logic               ay_neg;
  } div_side_t;

  // data riding along the cordic chain
  typedef struct packed {
    logic signed [31:0] x_off;
    logic signed [31:0] y_off;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               flip_a;
    logic               flip_h;
  } cordic_side_t;

  function automatic logic [31:0] atan_q29(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'd421657428;
      1:  r = 32'd248918915;
      2:  r = 32'd131521918;
      3:  r = 32'd66762579;
      4:  r = 32'd33510843;
      5:  r = 32'd16771758;
      6:  r = 32'd8387925;
      7:  r = 32'd4194219;
      8:  r = 32'd2097141;
      9:  r = 32'd1048575;
      10: r = 32'd524288;
      11: r = 32'd262144;
      12: r = 32'd131072;
      13: r = 32'd65536;
      14: r = 32'd32768;
      15: r = 32'd16384;
      16: r = 32'd8192;
      17: r = 32'd4096;
      18: r = 32'd2048;
      19: r = 32'd1024;
      20: r = 32'd512;
      21: r = 32'd256;
      22: r = 32'd128;
      23: r = 32'd64;
      24: r = 32'd32;
      25: r = 32'd16;
      26: r = 32'd8;
      27: r = 32'd4;
      28: r = 32'd2;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // fold the angle into the right half plane, remember the sign flip
  function automatic cordic_start_t cordic_start(input logic signed [31:0] a);
    cordic_start_t      r;
    logic signed [CW-1:0] aw;
    aw = CW'(a);
    r.lane.x = GAIN_Q30;
    r.lane.y = '0;
    if (a > HALF_PI_Q29) begin
      r.lane.z = aw - CW'(PI_Q29);
      r.flip   = 1'b1;
    end else if (a < -HALF_PI_Q29) begin
      r.lane.z = aw + CW'(PI_Q29);
      r.flip   = 1'b1;
    end else begin
      r.lane.z = aw;
      r.flip   = 1'b0;
    end
    return r;
  endfunction

endpackage

/* sv/ctp_div_cell.sv */
// ----------------------------------------------------------------------------
// ctp_div_cell
// One restoring division step for a few lanes sharing one divisor.
// ----------------------------------------------------------------------------
module ctp_div_cell #(
  parameter int DIV_W  = 17,
  parameter int QUOT_W = 33,
  parameter int LANES  = 1
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [DIV_W-1:0]                 div_i,
  input  logic [LANES-1:0][DIV_W-1:0]      rem_i,
  input  logic [LANES-1:0][QUOT_W-1:0]     num_i,
  output logic [DIV_W-1:0]                 div_o,
  output logic [LANES-1:0][DIV_W-1:0]      rem_o,
  output logic [LANES-1:0][QUOT_W-1:0]     num_o
);

  logic [LANES-1:0][DIV_W:0]      trial;
  logic [LANES-1:0][DIV_W:0]      diff;
  logic [LANES-1:0]               ge;
  logic [LANES-1:0][DIV_W-1:0]    rem_next;
  logic [LANES-1:0][QUOT_W-1:0]   num_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // bring down the next dividend bit, quotient bits shift in from the right
      trial[l]    = {rem_i[l], num_i[l][QUOT_W-1]};
      diff[l]     = trial[l] - {1'b0, div_i};
      ge[l]       = trial[l] >= {1'b0, div_i};
      rem_next[l] = ge[l] ? diff[l][DIV_W-1:0] : trial[l][DIV_W-1:0];
      num_next[l] = {num_i[l][QUOT_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_o <= div_i;
      rem_o <= rem_next;
      num_o <= num_next;
    end
  end

endmodule

/* sv/ctp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// ctp_cordic_cell
// One rotation-mode cordic iteration for the slice and half-bend angles.
// ----------------------------------------------------------------------------
module ctp_cordic_cell import ctp_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               en,
  input  cordic_lane_t [1:0] lane_i,
  output cordic_lane_t [1:0] lane_o
);

  localparam logic signed [CW-1:0] ATAN = CW'(atan_q29(STEP));

  cordic_lane_t [1:0] lane_next;
  logic signed [CW-1:0] dx [2];
  logic signed [CW-1:0] dy [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l] = $signed(lane_i[l].y) >>> STEP;
      dy[l] = $signed(lane_i[l].x) >>> STEP;
      if (!lane_i[l].z[CW-1]) begin
        lane_next[l].x = $signed(lane_i[l].x) - dx[l];
        lane_next[l].y = $signed(lane_i[l].y) + dy[l];
        lane_next[l].z = $signed(lane_i[l].z) - ATAN;
      end else begin
        lane_next[l].x = $signed(lane_i[l].x) + dx[l];
        lane_next[l].y = $signed(lane_i[l].y) - dy[l];
        lane_next[l].z = $signed(lane_i[l].z) + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_o <= lane_next;
    end
  end

endmodule

/* sv/curved_to_plane_momentum_transform.sv */
// ----------------------------------------------------------------------------
// curved_to_plane_momentum_transform
// Slice angle, Cartesian position and rotated momentum of one particle.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while no response is held, a 33-cell divider chain then a cordic chain
// the whole pipeline holds while a response waits on rsp_stall
// reset clears the pipeline valids and loads radius 1.0, angle 0, count 1
module curved_to_plane_momentum_transform import ctp_pkg::*; #(
  parameter int CORDIC_STEPS = 24,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NQ_W = 64 - FRAC_BITS;

  // configuration
  logic [30:0]        bend_radius;
  logic signed [31:0] bend_angle;
  logic [15:0]        slice_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bend_radius <= 31'd65536;
      bend_angle  <= '0;
      slice_count <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BEND_RADIUS: bend_radius <= pwdata[30:0];
        REG_BEND_ANGLE:  bend_angle  <= pwdata;
        REG_SLICE_COUNT: slice_count <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BEND_RADIUS: prdata = {1'b0, bend_radius};
      REG_BEND_ANGLE:  prdata = bend_angle;
      REG_SLICE_COUNT: prdata = {16'd0, slice_count};
      default:         prdata = '0;
    endcase
  end

  logic adv;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // valid line
  logic                  v1;
  logic [DIV_STEPS:0]    dv;
  logic [CORDIC_STEPS:0] cv;
  logic                  v4;
  logic                  v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      dv        <= '0;
      cv        <= '0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      v1        <= req_valid;
      dv        <= {dv[DIV_STEPS-1:0], v1};
      cv        <= {cv[CORDIC_STEPS-1:0], dv[DIV_STEPS]};
      v4        <= cv[CORDIC_STEPS];
      v5        <= v4;
      rsp_valid <= v5;
    end
  end

  // stage 1: products feeding the dividers
  logic [15:0]                 n_eff;
  logic [ANG_DIV_W-1:0]        ang_div;
  logic signed [17:0]          idx_term;
  logic signed [31:0]          p_s;
  logic signed [ANG_PROD_W-1:0] prod_ang_next;
  logic signed [63:0]          ax2_next;
  logic signed [63:0]          ay2_next;
  logic signed [63:0]          pax_next;
  logic signed [63:0]          pay_next;

  assign n_eff    = (slice_count == 16'd0) ? 16'd1 : slice_count;
  assign ang_div  = {n_eff, 1'b0};
  assign idx_term = $signed({1'b0, req.slice_index, 1'b0}) - $signed({2'b00, n_eff});
  assign p_s      = $signed({1'b0, req.momentum});

  assign prod_ang_next = bend_angle * idx_term;
  assign ax2_next      = req.x_slope * req.x_slope;
  assign ay2_next      = req.y_slope * req.y_slope;
  assign pax_next      = p_s * req.x_slope;
  assign pay_next      = p_s * req.y_slope;

  logic signed [31:0]           s1_x;
  logic signed [31:0]           s1_y;
  logic signed [ANG_PROD_W-1:0] prod_ang;
  logic [63:0]                  ax2;
  logic [63:0]                  ay2;
  logic signed [63:0]           pax;
  logic signed [63:0]           pay;
  logic [63:0]                  pzn;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x     <= req.x_offset;
      s1_y     <= req.y_offset;
      prod_ang <= prod_ang_next;
      ax2      <= ax2_next;
      ay2      <= ay2_next;
      pax      <= pax_next;
      pay      <= pay_next;
      pzn      <= {33'd0, req.momentum} << FRAC_BITS;
    end
  end

  // stage 2: magnitudes, norm and divider seeds
  logic [ANG_PROD_W-2:0] ang_mag;
  logic [ANG_PROD_W-2:0] ang_hi;
  logic [63:0]           norm;
  logic [63:0]           mag_px;
  logic [63:0]           mag_py;

  assign ang_mag = prod_ang[ANG_PROD_W-1] ? (ANG_PROD_W-1)'(-prod_ang)
                                          : (ANG_PROD_W-1)'(prod_ang);
  assign ang_hi  = ang_mag >> DIV_STEPS;
  assign norm    = (64'd1 << (2 * FRAC_BITS)) + ax2 + ay2;
  assign mag_px  = pax[63] ? 64'(-pax) : 64'(pax);
  assign mag_py  = pay[63] ? 64'(-pay) : 64'(pay);

  logic [ANG_DIV_W-1:0]              ad_div [DIV_STEPS+1];
  logic [0:0][ANG_DIV_W-1:0]         ad_rem [DIV_STEPS+1];
  logic [0:0][DIV_STEPS-1:0]         ad_num [DIV_STEPS+1];
  logic [NQ_W-1:0]                   md_div [DIV_STEPS+1];
  logic [2:0][NQ_W-1:0]              md_rem [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0]         md_num [DIV_STEPS+1];
  div_side_t                         ds     [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ad_div[0]       <= ang_div;
      ad_rem[0][0]    <= ANG_DIV_W'(ang_hi);
      ad_num[0][0]    <= ang_mag[DIV_STEPS-1:0];
      md_div[0]       <= NQ_W'(norm >> FRAC_BITS);
      md_rem[0][0]    <= NQ_W'(mag_px >> DIV_STEPS);
      md_rem[0][1]    <= NQ_W'(mag_py >> DIV_STEPS);
      md_rem[0][2]    <= NQ_W'(pzn >> DIV_STEPS);
      md_num[0][0]    <= mag_px[DIV_STEPS-1:0];
      md_num[0][1]    <= mag_py[DIV_STEPS-1:0];
      md_num[0][2]    <= pzn[DIV_STEPS-1:0];
      ds[0].x_off     <= s1_x;
      ds[0].y_off     <= s1_y;
      ds[0].ang_neg   <= prod_ang[ANG_PROD_W-1];
      // quotient would not fit the chain, so it saturates anyway
      ds[0].ang_ovf   <= ang_hi >= (ANG_PROD_W-1)'(ang_div);
      ds[0].ax_neg    <= pax[63];
      ds[0].ay_neg    <= pay[63];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    ctp_div_cell #(
      .DIV_W  (ANG_DIV_W),
      .QUOT_W (DIV_STEPS),
      .LANES  (1)
    ) u_ang (
      .clk   (clk),
      .en    (adv),
      .div_i (ad_div[k]),
      .rem_i (ad_rem[k]),
      .num_i (ad_num[k]),
      .div_o (ad_div[k+1]),
      .rem_o (ad_rem[k+1]),
      .num_o (ad_num[k+1])
    );

    ctp_div_cell #(
      .DIV_W  (NQ_W),
      .QUOT_W (DIV_STEPS),
      .LANES  (3)
    ) u_mom (
      .clk   (clk),
      .en    (adv),
      .div_i (md_div[k]),
      .rem_i (md_rem[k]),
      .num_i (md_num[k]),
      .div_o (md_div[k+1]),
      .rem_o (md_rem[k+1]),
      .num_o (md_num[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k+1] <= ds[k];
      end
    end
  end

  // stage 3: signed quotients, saturated slice angle, cordic seeds
  div_side_t             dq;
  logic signed [DIV_STEPS:0] ang_q;
  logic signed [31:0]    ang;
  cordic_start_t         st_a;
  cordic_start_t         st_h;
  logic signed [31:0]    qx;
  logic signed [31:0]    qy;

  assign dq    = ds[DIV_STEPS];
  assign ang_q = dq.ang_neg ? -$signed({1'b0, ad_num[DIV_STEPS][0]})
                            : $signed({1'b0, ad_num[DIV_STEPS][0]});

  always_comb begin
    if (dq.ang_ovf) begin
      ang = dq.ang_neg ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      ang = sat32(64'(ang_q));
    end
  end

  assign st_a = cordic_start(ang);
  assign st_h = cordic_start(bend_angle >>> 1);
  assign qx   = md_num[DIV_STEPS][0][31:0];
  assign qy   = md_num[DIV_STEPS][1][31:0];

  cordic_lane_t [1:0] cl [CORDIC_STEPS+1];
  cordic_side_t       cs [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cl[0][0]     <= st_a.lane;
      cl[0][1]     <= st_h.lane;
      cs[0].x_off  <= dq.x_off;
      cs[0].y_off  <= dq.y_off;
      cs[0].px     <= dq.ax_neg ? -qx : qx;
      cs[0].py     <= dq.ay_neg ? -qy : qy;
      cs[0].pz     <= md_num[DIV_STEPS][2][31:0];
      cs[0].flip_a <= st_a.flip;
      cs[0].flip_h <= st_h.flip;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    ctp_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk    (clk),
      .en     (adv),
      .lane_i (cl[k]),
      .lane_o (cl[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        cs[k+1] <= cs[k];
      end
    end
  end

  // stage 4: sine and cosine, radius terms
  cordic_side_t       ce;
  logic signed [31:0] c_next;
  logic signed [31:0] s_next;
  logic signed [31:0] ch_next;
  logic signed [33:0] half_sum;
  logic signed [32:0] d_next;

  assign ce       = cs[CORDIC_STEPS];
  assign c_next   = ce.flip_a ? -cl[CORDIC_STEPS][0].x[31:0] : cl[CORDIC_STEPS][0].x[31:0];
  assign s_next   = ce.flip_a ? -cl[CORDIC_STEPS][0].y[31:0] : cl[CORDIC_STEPS][0].y[31:0];
  assign ch_next  = ce.flip_h ? -cl[CORDIC_STEPS][1].x[31:0] : cl[CORDIC_STEPS][1].x[31:0];
  assign half_sum = 34'sd1073741824 + 34'(ch_next);
  assign d_next   = 33'(c_next) - 33'(half_sum >>> 1);

  logic signed [31:0] c4;
  logic signed [31:0] s4;
  logic signed [32:0] d4;
  logic signed [32:0] rx4;
  cordic_side_t       side4;

  always_ff @(posedge clk) begin
    if (adv) begin
      c4    <= c_next;
      s4    <= s_next;
      d4    <= d_next;
      rx4   <= $signed({2'b00, bend_radius}) + 33'(ce.x_off);
      side4 <= ce;
    end
  end

  // stage 5: products
  logic signed [32:0] rho_s;
  assign rho_s = $signed({2'b00, bend_radius});

  logic signed [63:0] rd_next;
  logic signed [63:0] xc_next;
  logic signed [63:0] rs_next;
  logic signed [63:0] pc_next;
  logic signed [63:0] zs_next;
  logic signed [63:0] ps_next;
  logic signed [63:0] zc_next;

  assign rd_next = rho_s * d4;
  assign xc_next = side4.x_off * c4;
  assign rs_next = rx4 * s4;
  assign pc_next = side4.px * c4;
  assign zs_next = side4.pz * s4;
  assign ps_next = side4.px * s4;
  assign zc_next = side4.pz * c4;

  logic signed [63:0] rd5;
  logic signed [63:0] xc5;
  logic signed [63:0] rs5;
  logic signed [63:0] pc5;
  logic signed [63:0] zs5;
  logic signed [63:0] ps5;
  logic signed [63:0] zc5;
  logic signed [31:0] y5;
  logic signed [31:0] py5;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd5 <= rd_next;
      xc5 <= xc_next;
      rs5 <= rs_next;
      pc5 <= pc_next;
      zs5 <= zs_next;
      ps5 <= ps_next;
      zc5 <= zc_next;
      y5  <= side4.y_off;
      py5 <= side4.py;
    end
  end

  // output register
  logic signed [63:0] sum_px;
  logic signed [63:0] sum_mx;
  logic signed [63:0] sum_mz;

  assign sum_px = rd5 + xc5;
  assign sum_mx = pc5 - zs5;
  assign sum_mz = ps5 + zc5;

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.pos_x <= sat32(sum_px >>> 30);
      rsp.pos_y <= y5;
      rsp.pos_z <= sat32(rs5 >>> 30);
      rsp.mom_x <= sat32(sum_mx >>> 30);
      rsp.mom_y <= py5;
      rsp.mom_z <= sat32(sum_mz >>> 30);
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> v1)
    else $error("accepted request did not enter the pipeline");

  a_reset_clears : assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_hold_freezes : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> ($stable(dv) && $stable(cv) && $stable(v5)))
    else $error("pipeline moved while the response was held");
`endif

endmodule

/* dv/curved_to_plane_momentum_transform_chk.sv */
// ----------------------------------------------------------------------------
// curved_to_plane_momentum_transform_chk
// Watches the request, response and register ports of the transform, predicts
// each particle's Cartesian position and rotated momentum, and compares.
// ----------------------------------------------------------------------------
module curved_to_plane_momentum_transform_chk import ctp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_STEPS = 24;
  localparam int FRAC      = 16;
  localparam longint PI_A   = 64'sd1686629713;
  localparam longint HPI_A  = 64'sd843314857;
  localparam longint GAIN_A = 64'sd652032874;
  localparam longint ARCTAN [ROT_STEPS] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925,
    4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
    8192, 4096, 2048, 1024, 512, 256, 128, 64};

  logic [30:0]        radius_cfg;
  logic signed [31:0] angle_cfg;
  logic [15:0]        count_cfg;
  rsp_t               expected_tracks [$];
  rsp_t               want;

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void sin_cos_q30(input longint a, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    flip = 0;
    x = GAIN_A;
    y = 0;
    if (a > HPI_A) begin
      a = a - PI_A;
      flip = 1;
    end else if (a < -HPI_A) begin
      a = a + PI_A;
      flip = 1;
    end
    z = a;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic rsp_t transform_particle(input req_t r);
    longint X, Y, ax, ay, p, idx, n, rho, th, ang, c, s, ch, sh, d;
    longint px, py, pz, nq;
    longint unsigned norm;
    rsp_t o;
    X = r.x_offset;
    Y = r.y_offset;
    ax = r.x_slope;
    ay = r.y_slope;
    p = longint'({33'd0, r.momentum});
    idx = longint'({48'd0, r.slice_index});
    n = (count_cfg == 0) ? 1 : longint'({48'd0, count_cfg});
    rho = longint'({33'd0, radius_cfg});
    th = angle_cfg;
    ang = clip32((th * (2 * idx - n)) / (2 * n));
    sin_cos_q30(ang, c, s);
    sin_cos_q30(th >>> 1, ch, sh);
    d = c - (((64'sd1 <<< 30) + ch) >>> 1);
    o.pos_x = clip32((rho * d + X * c) >>> 30);
    o.pos_y = Y[31:0];
    o.pos_z = clip32(((rho + X) * s) >>> 30);
    norm = (64'd1 << (2 * FRAC)) + longint'(ax * ax) + longint'(ay * ay);
    nq = longint'(norm >> FRAC);
    px = (p * ax) / nq;
    py = (p * ay) / nq;
    pz = (p <<< FRAC) / nq;
    o.mom_x = clip32((px * c - pz * s) >>> 30);
    o.mom_y = clip32(py);
    o.mom_z = clip32((px * s + pz * c) >>> 30);
    return o;
  endfunction

  assign outstanding = expected_tracks.size();

  always @(posedge clk) begin
    if (rst) begin
      radius_cfg <= 31'd65536;
      angle_cfg  <= '0;
      count_cfg  <= 16'd1;
      fail_count <= 0;
      expected_tracks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BEND_RADIUS: radius_cfg <= pwdata[30:0];
          REG_BEND_ANGLE:  angle_cfg  <= pwdata;
          REG_SLICE_COUNT: count_cfg  <= pwdata[15:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) expected_tracks.push_back(transform_particle(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_tracks.size() == 0) begin
          $error("response with no request waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_tracks.pop_front();
          if (rsp != want) begin
            fail_count <= fail_count + 1;
            if (rsp.pos_x != want.pos_x)
              $error("pos_x: expected %0d, got %0d", want.pos_x, rsp.pos_x);
            if (rsp.pos_y != want.pos_y)
              $error("pos_y: expected %0d, got %0d", want.pos_y, rsp.pos_y);
            if (rsp.pos_z != want.pos_z)
              $error("pos_z: expected %0d, got %0d", want.pos_z, rsp.pos_z);
            if (rsp.mom_x != want.mom_x)
              $error("mom_x: expected %0d, got %0d", want.mom_x, rsp.mom_x);
            if (rsp.mom_y != want.mom_y)
              $error("mom_y: expected %0d, got %0d", want.mom_y, rsp.mom_y);
            if (rsp.mom_z != want.mom_z)
              $error("mom_z: expected %0d, got %0d", want.mom_z, rsp.mom_z);
          end
        end
      end
    end
  end

endmodule

/* dv/curved_to_plane_momentum_transform_tb.sv */
// ----------------------------------------------------------------------------
// curved_to_plane_momentum_transform_tb
// Streams particles through the transform under several magnet settings and
// flow-control patterns; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module curved_to_plane_momentum_transform_tb import ctp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_off;
  int          cycles;
  logic [15:0] slices;

  curved_to_plane_momentum_transform u_dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  curved_to_plane_momentum_transform_chk u_chk (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .outstanding
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("curved_to_plane_momentum_transform_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off to back the pipe up
  initial begin
    rsp_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_stall <= 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_magnet(input logic [30:0] rad, input logic [31:0] ang,
                            input logic [15:0] cnt);
    while (outstanding != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    reg_write(REG_BEND_RADIUS, {1'b0, rad});
    reg_write(REG_BEND_ANGLE, ang);
    reg_write(REG_SLICE_COUNT, cnt);
    slices = cnt;
  endtask

  task automatic send_particle(input req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req <= r;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      1: return $urandom_range(0, 32'h400) - 32'h200;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_particle();
    req_t r;
    r.x_offset = pick32();
    r.y_offset = pick32();
    r.x_slope  = pick32();
    r.y_slope  = pick32();
    r.momentum = ($urandom_range(0, 1) != 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    if ($urandom_range(0, 9) == 0) r.slice_index = 16'($urandom);
    else r.slice_index = 16'($urandom_range(0, slices));
    return r;
  endfunction

  function automatic req_t particle(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] ax, input logic [31:0] ay,
                                    input logic [30:0] p, input logic [15:0] i);
    req_t r;
    r.x_offset = x; r.y_offset = y; r.x_slope = ax; r.y_slope = ay;
    r.momentum = p; r.slice_index = i;
    return r;
  endfunction

  initial begin
    logic [30:0] rads [5];
    logic [31:0] angs [5];
    logic [15:0] cnts [5];
    int          modes [4][2];
    rads = '{31'd65536, 31'h7fffffff, 31'd0, 31'd1, 31'd196608};
    angs = '{32'd0, PI_Q29, -PI_Q29, 32'd12345678, -HALF_PI_Q29};
    cnts = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd16};
    modes = '{'{0, 0}, '{79, 0}, '{0, 79}, '{24, 24}};
    rst = 1;
    req_valid = 0;
    req = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    slices = 1;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: field extremes, angle past a right angle, index past count
    set_magnet(31'd655360, PI_Q29, 16'd4);
    send_particle(particle(0, 0, 0, 0, 31'd65536, 0));
    send_particle(particle(32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff, 0));
    send_particle(particle(32'h7fffffff, 32'h7fffffff, 0, 0, 31'h7fffffff, 4));
    send_particle(particle(32'h10000, 0, 32'h80000000, 32'h80000000, 31'h7fffffff, 2));
    send_particle(particle(32'h10000, 0, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1));
    send_particle(particle(0, 0, 32'h80000000, 0, 31'd0, 3));
    send_particle(particle(0, 0, 0, 32'h7fffffff, 31'h7fffffff, 16'hffff));
    send_particle(particle(32'hffff0000, 32'h1, 32'h10000, 32'hffff0000, 31'd65536, 5));
    send_particle(particle(32'h7fffffff, 0, 32'h8000, 32'h8000, 31'h7fffffff, 16'd9));
    send_particle(particle(32'h80000000, 0, 32'hffffffff, 32'h1, 31'h1, 0));
    send_particle(particle(32'h12345678, 32'hedcba987, 32'h55555555, 32'haaaaaaaa,
                           31'h2aaaaaaa, 16'h5555));
    send_particle(particle(32'hedcba987, 32'h12345678, 32'haaaaaaaa, 32'h55555555,
                           31'h55555555, 16'haaaa));
    req_valid <= 0;

    for (int k = 0; k < 5; k++) begin
      set_magnet(rads[k], angs[k], cnts[k]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = modes[m][0];
        stall_pct = modes[m][1];
        if (k == 1 && m == 0) hold_off = 1;
        for (int j = 0; j < 57; j++) send_particle(random_particle());
        req_valid <= 0;
        @(posedge clk);
      end
      send_idle_pct = 0;
      stall_pct = 0;
    end

    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("curved_to_plane_momentum_transform_tb: done, clean");
    end else begin
      $display("curved_to_plane_momentum_transform_tb: done, errors");
    end
    $finish;
  end

endmodule
